// File: src/cerl_pkg.sv
// Shared types, codes and helpers for the CAN error report limiter.
package cerl_pkg;

    // Width of the application flag word
    localparam int FLAG_WIDTH = 16;
    // Packed snapshot: flags, bus state, back-to-active, tx, rx, protocol code
    localparam int SNAP_WIDTH = FLAG_WIDTH + 2 + 1 + 8 + 8 + 3;

    // Command codes
    localparam logic [1:0] CMD_ASSERT = 2'd0;
    localparam logic [1:0] CMD_POLL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Bus status codes
    localparam logic [1:0] BUS_ACTIVE  = 2'd0;
    localparam logic [1:0] BUS_WARNING = 2'd1;
    localparam logic [1:0] BUS_PASSIVE = 2'd2;
    localparam logic [1:0] BUS_OFF     = 2'd3;

    // Protocol error codes with special meaning
    localparam logic [2:0] PROTO_NONE      = 3'd0;
    localparam logic [2:0] PROTO_NO_CHANGE = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_REPORT_ENABLE  = 2'd0;
    localparam logic [1:0] REG_SHORT_INTERVAL = 2'd1;
    localparam logic [1:0] REG_LONG_INTERVAL  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] SHORT_INTERVAL_RESET = 16'd100;
    localparam logic [15:0] LONG_INTERVAL_RESET  = 16'd3000;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [FLAG_WIDTH-1:0] flag_bits;
        logic                  urgent;
        logic                  bus_open;
        logic                  warn_flag;
        logic                  passive_flag;
        logic                  busoff_flag;
        logic [2:0]            data_phase_error;
        logic [2:0]            arb_phase_error;
        logic [7:0]            tx_errors;
        logic [7:0]            rx_errors;
        logic [31:0]           tick_ms;
    } cerl_item_t;

    typedef struct packed {
        logic                  report_enable;
        logic [15:0]           short_interval;
        logic [15:0]           long_interval;
    } cerl_cfg_t;

    typedef struct packed {
        logic [FLAG_WIDTH-1:0] flags;
        logic [1:0]            bus_state;
        logic                  back_active;
        logic [7:0]            tx_count;
        logic [7:0]            rx_count;
        logic [2:0]            proto_code;
        logic [SNAP_WIDTH-1:0] prev_snapshot;
        logic [31:0]           prev_tick;
        logic                  urgent_pending;
    } cerl_state_t;

    typedef struct packed {
        logic                  report_due;
        logic [FLAG_WIDTH-1:0] flags;
        logic [1:0]            bus_state;
        logic                  back_active;
        logic [7:0]            tx_errors;
        logic [7:0]            rx_errors;
        logic [2:0]            proto_error;
    } cerl_result_t;

    // Pack the current snapshot, flags in the low bits
    function automatic logic [SNAP_WIDTH-1:0] pack_snapshot(
        input logic [FLAG_WIDTH-1:0] flags,
        input logic [1:0]            bus_state,
        input logic                  back_active,
        input logic [7:0]            tx_count,
        input logic [7:0]            rx_count,
        input logic [2:0]            proto_code
    );
        return {proto_code, rx_count, tx_count, back_active, bus_state, flags};
    endfunction

    // A protocol code that names a real error
    function automatic logic proto_valid(input logic [2:0] code);
        return (code != PROTO_NONE) && (code != PROTO_NO_CHANGE);
    endfunction

endpackage

// File: src/cerl_cfg_regs.sv
// Configuration register file of the CAN error report limiter.
module cerl_cfg_regs
    import cerl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cerl_cfg_t   cfg
);

    logic        report_enable_reg;
    logic [15:0] short_interval_reg;
    logic [15:0] long_interval_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_enable_reg  <= 1'b1;
            short_interval_reg <= SHORT_INTERVAL_RESET;
            long_interval_reg  <= LONG_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REPORT_ENABLE:  report_enable_reg  <= cfg_data[0];
                REG_SHORT_INTERVAL: short_interval_reg <= cfg_data;
                REG_LONG_INTERVAL:  long_interval_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.report_enable  = report_enable_reg;
    assign cfg.short_interval = short_interval_reg;
    assign cfg.long_interval  = long_interval_reg;

endmodule

// File: src/cerl_step.sv
// Next-state and report decision for one word of the CAN error report limiter.
module cerl_step
    import cerl_pkg::*;
(
    input  cerl_item_t   item,
    input  cerl_cfg_t    cfg,
    input  cerl_state_t  state,
    output cerl_state_t  state_next,
    output cerl_result_t result
);

    logic [1:0]            bus_next;
    logic [1:0]            prev_bus;
    logic                  back_next;
    logic [2:0]            proto_next;
    logic [SNAP_WIDTH-1:0] snap_next;
    logic [31:0]           elapsed;
    logic                  poll_live;
    logic                  report;

    assign prev_bus  = state.prev_snapshot[FLAG_WIDTH +: 2];
    assign poll_live = (item.cmd == CMD_POLL) && cfg.report_enable && item.bus_open;
    assign elapsed   = item.tick_ms - state.prev_tick;

    // Sampled snapshot fields for a live poll
    always_comb
    begin
        bus_next = state.bus_state;
        if (item.warn_flag)
            bus_next = BUS_WARNING;
        if (item.passive_flag)
            bus_next = BUS_PASSIVE;
        if (item.busoff_flag)
            bus_next = BUS_OFF;

        back_next = state.back_active
                    | ((bus_next == BUS_ACTIVE) && (prev_bus != BUS_ACTIVE));

        // First error latches; arbitration phase wins over data phase
        proto_next = state.proto_code;
        if (state.proto_code == PROTO_NONE)
        begin
            if (proto_valid(item.data_phase_error))
                proto_next = item.data_phase_error;
            if (proto_valid(item.arb_phase_error))
                proto_next = item.arb_phase_error;
        end
    end

    assign snap_next = pack_snapshot(state.flags, bus_next, back_next,
                                     item.tx_errors, item.rx_errors, proto_next);

    // Report decision
    always_comb
    begin
        priority if (state.urgent_pending)
            report = 1'b1;
        else if (snap_next == '0)
            report = 1'b0;
        else if ((bus_next == BUS_OFF) && (prev_bus != BUS_OFF))
            report = 1'b1;
        else if (elapsed < {16'd0, cfg.short_interval})
            report = 1'b0;
        else if (snap_next != state.prev_snapshot)
            report = 1'b1;
        else
            report = elapsed >= {16'd0, cfg.long_interval};
    end

    // State update by command
    always_comb
    begin
        state_next = state;
        unique case (item.cmd)
            CMD_ASSERT:
            begin
                state_next.flags = state.flags | item.flag_bits;
                if (item.urgent)
                    state_next.urgent_pending = 1'b1;
            end
            CMD_POLL:
            begin
                if (poll_live)
                begin
                    state_next.bus_state      = bus_next;
                    state_next.back_active    = back_next;
                    state_next.tx_count       = item.tx_errors;
                    state_next.rx_count       = item.rx_errors;
                    state_next.proto_code     = proto_next;
                    state_next.urgent_pending = 1'b0;
                    if (report)
                    begin
                        state_next.prev_snapshot = snap_next;
                        state_next.prev_tick     = item.tick_ms;
                    end
                end
            end
            CMD_CLEAR:
            begin
                state_next.flags       = '0;
                state_next.bus_state   = BUS_ACTIVE;
                state_next.back_active = 1'b0;
                state_next.tx_count    = '0;
                state_next.rx_count    = '0;
                state_next.proto_code  = PROTO_NONE;
            end
            default: ;
        endcase
    end

    // Result shows the snapshot after the word is applied
    assign result.report_due  = poll_live && report;
    assign result.flags       = state_next.flags;
    assign result.bus_state   = state_next.bus_state;
    assign result.back_active = state_next.back_active;
    assign result.tx_errors   = state_next.tx_count;
    assign result.rx_errors   = state_next.rx_count;
    assign result.proto_error = state_next.proto_code;

endmodule

// File: src/can_error_report_limiter.sv
// CAN error report limiter for one channel: decides when the error state is reported.
//
// Channels: input words (cmd and fields) on in_valid/in_ready, one result word per
// input word on out_valid/out_ready, register writes on cfg_valid/cfg_ready with
// cfg_index (0 report_enable, 1 short_interval, 2 long_interval) and cfg_data.
// cfg_ready is always high; writes belong in idle periods.
// Path: a word accepted into the input stage register is processed combinationally, and
// its result word is registered in the output register once that register is free or
// being taken; the receiver takes it from there on out_valid/out_ready.
// Throughput: one word per cycle while the output is not stalled; the snapshot state
// updates through one subtract and a few compares between the input and output registers.
// Stall: when out_ready is low the result word holds, the input stage holds one
// more word, and in_ready drops once both are full. No word is lost or repeated.
// Reset: snapshot, last report copy, urgent request and handshake state clear;
// report_enable resets to 1, short_interval to 100, long_interval to 3000.
module can_error_report_limiter
    import cerl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    // Input words
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [FLAG_WIDTH-1:0] flag_bits,
    input  logic                  urgent,
    input  logic                  bus_open,
    input  logic                  warn_flag,
    input  logic                  passive_flag,
    input  logic                  busoff_flag,
    input  logic [2:0]            data_phase_error,
    input  logic [2:0]            arb_phase_error,
    input  logic [7:0]            tx_errors,
    input  logic [7:0]            rx_errors,
    input  logic [31:0]           tick_ms,
    // Result words
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  report_due,
    output logic [FLAG_WIDTH-1:0] out_flags,
    output logic [1:0]            out_bus_state,
    output logic                  out_back_active,
    output logic [7:0]            out_tx_errors,
    output logic [7:0]            out_rx_errors,
    output logic [2:0]            out_proto_error
);

    cerl_cfg_t    cfg;
    cerl_item_t   item_reg;
    logic         item_valid_reg;
    cerl_state_t  state_reg;
    cerl_state_t  state_next;
    cerl_result_t step_result;
    cerl_result_t result_reg;
    logic         out_valid_reg;
    logic         out_load;
    logic         in_take;

    cerl_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cerl_step u_step (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Handshake: the input stage moves on when the output register is free
    assign out_load = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || out_load;
    assign in_take  = in_valid && in_ready;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd              <= cmd;
            item_reg.flag_bits        <= flag_bits;
            item_reg.urgent           <= urgent;
            item_reg.bus_open         <= bus_open;
            item_reg.warn_flag        <= warn_flag;
            item_reg.passive_flag     <= passive_flag;
            item_reg.busoff_flag      <= busoff_flag;
            item_reg.data_phase_error <= data_phase_error;
            item_reg.arb_phase_error  <= arb_phase_error;
            item_reg.tx_errors        <= tx_errors;
            item_reg.rx_errors        <= rx_errors;
            item_reg.tick_ms          <= tick_ms;
        end
    end

    // Snapshot state advances with each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (out_load)
            state_reg <= state_next;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= step_result;
    end

    assign out_valid       = out_valid_reg;
    assign report_due      = result_reg.report_due;
    assign out_flags       = result_reg.flags;
    assign out_bus_state   = result_reg.bus_state;
    assign out_back_active = result_reg.back_active;
    assign out_tx_errors   = result_reg.tx_errors;
    assign out_rx_errors   = result_reg.rx_errors;
    assign out_proto_error = result_reg.proto_error;

`ifndef SYNTHESIS
    // A shown report matches the stored last-report copy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.report_due) |->
        (state_reg.prev_snapshot == pack_snapshot(result_reg.flags, result_reg.bus_state,
            result_reg.back_active, result_reg.tx_errors, result_reg.rx_errors,
            result_reg.proto_error)))
        else $error("reported word differs from last-report copy");

    // An urgent request is only consumed by a reporting poll
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg.urgent_pending) |-> (out_valid_reg && result_reg.report_due))
        else $error("urgent request dropped without a report");

    // No report is produced while reporting is disabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !cfg.report_enable) |=> !result_reg.report_due)
        else $error("report issued while reporting disabled");
`endif

endmodule
